### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset
`define WTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication, disabled while in reset
`define WTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`else

`define WTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### sv/wts_pkg.sv
`default_nettype none

package wts_pkg;

	// field widths
	localparam int SLOT_W  = 3;
	localparam int DELAY_W = 32;
	localparam int TIME_W  = 64;

	localparam int TIMER_SLOTS_DEF = 8;

	localparam logic [DELAY_W-1:0] MAX_DELAY = 32'hFFFF_FFFF;

	// input word kinds
	localparam logic KIND_ARM = 1'b0;
	localparam logic KIND_ADV = 1'b1;

	// running summary handed from cell to cell
	typedef struct packed {
		logic               any_wait;
		logic               any_zero;
		logic [DELAY_W-1:0] min_left;
	} wts_chain_t;

	// per-cell commands
	typedef struct packed {
		logic arm;
		logic sub;
		logic clr;
	} wts_cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_IDLE_OUT,
		ST_WALK,
		ST_FLUSH
	} wts_state_t;

endpackage

`default_nettype wire

### sv/wts_cell.sv
`default_nettype none

// One timer slot: remaining time, waiting mark and one stage of the minimum chain
module wts_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire wts_pkg::wts_cell_ctl_t       ctl,
	input  wire logic [wts_pkg::DELAY_W-1:0]  arm_delay,
	input  wire logic [wts_pkg::DELAY_W-1:0]  sub_val,
	input  wire wts_pkg::wts_chain_t          chain_in,
	output wts_pkg::wts_chain_t               chain_out,
	output logic                              fire
);

	logic [wts_pkg::DELAY_W-1:0] rem_q;
	logic                        wait_q;
	wts_pkg::wts_chain_t         chain_q;
	logic                        at_zero;

	assign at_zero   = (rem_q == '0);
	assign fire      = wait_q && at_zero;
	assign chain_out = chain_q;

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= 1'b0;
		end else if (ctl.arm) begin
			wait_q <= 1'b1;
		end else if (ctl.clr) begin
			wait_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.arm) begin
			rem_q <= arm_delay;
		end else if (ctl.sub && wait_q) begin
			rem_q <= rem_q - sub_val;
		end
	end

	// fold this slot into the running summary, one stage per cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '{any_wait: 1'b0, any_zero: 1'b0, min_left: wts_pkg::MAX_DELAY};
		end else begin
			chain_q.any_wait <= chain_in.any_wait | wait_q;
			chain_q.any_zero <= chain_in.any_zero | fire;
			chain_q.min_left <= (wait_q && (rem_q < chain_in.min_left)) ? rem_q
			                                                          : chain_in.min_left;
		end
	end

endmodule

`default_nettype wire

### sv/waiting_timer_slice_scheduler_core.sv
`default_nettype none

// Timer slot scheduler. An arm word (tuser = 0) loads one slot's 32-bit delay and
// marks it waiting; it gives no result. An advance word (tuser = 1) either fires
// waiting slots already at zero, or moves the 64-bit clock to the earliest expiry
// and fires every slot reaching zero; one result word per fired slot in ascending
// slot order, tlast on the final one, or a single idle word (tuser = 1, tlast = 1)
// when nothing waits. An advance runs through the accepting cycle, a scan while the
// minimum ripples down the row of slot cells, a step to subtract and bump the clock,
// a walk over the slots for reports and a flush of the final report, and any output
// stall holds it. An idle advance gives its idle word in place of the walk and the
// flush. The result register lets the next word be taken while the last report
// waits.
module waiting_timer_slice_scheduler_core #(
	parameter int TIMER_SLOTS = wts_pkg::TIMER_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // slot[2:0], delay[34:3], zero pad
	input  wire logic        s_axis_tuser,   // kind

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // fired_slot[2:0], now_time[66:3], zero pad
	output logic             m_axis_tuser,   // idle
	output logic             m_axis_tlast    // last
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CMP_W = (IDX_W > wts_pkg::SLOT_W) ? IDX_W : wts_pkg::SLOT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

	// input unpacking
	logic [wts_pkg::SLOT_W-1:0]  in_slot;
	logic [wts_pkg::DELAY_W-1:0] in_delay;
	logic                        in_acc;
	logic                        arm_acc;
	logic                        adv_acc;

	assign in_slot  = s_axis_tdata[2:0];
	assign in_delay = s_axis_tdata[34:3];
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign arm_acc  = in_acc && (s_axis_tuser == wts_pkg::KIND_ARM);
	assign adv_acc  = in_acc && (s_axis_tuser == wts_pkg::KIND_ADV);

	wts_pkg::wts_state_t state_q, state_nxt;

	logic [IDX_W-1:0]            cnt_q;
	logic [IDX_W-1:0]            pend_q;
	logic                        pend_v_q;
	logic [wts_pkg::TIME_W-1:0]  clock_q;

	// output register
	logic                        out_v_q;
	logic [wts_pkg::SLOT_W-1:0]  out_slot_q;
	logic [wts_pkg::TIME_W-1:0]  out_time_q;
	logic                        out_idle_q;
	logic                        out_last_q;
	logic                        out_free;

	assign out_free = !out_v_q || m_axis_tready;

	// cell row
	wts_pkg::wts_chain_t chain [0:TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] fire_vec;
	wts_pkg::wts_chain_t    summary;

	logic sub_en;
	logic clr_en;

	assign chain[0] = '{any_wait: 1'b0, any_zero: 1'b0, min_left: wts_pkg::MAX_DELAY};
	assign summary  = chain[TIMER_SLOTS];

	for (genvar gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
		wts_pkg::wts_cell_ctl_t ctl;

		assign ctl.arm = arm_acc && (CMP_W'(in_slot) == CMP_W'(gi));
		assign ctl.sub = sub_en;
		assign ctl.clr = clr_en && (cnt_q == IDX_W'(gi));

		wts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.arm_delay(in_delay),
			.sub_val  (summary.min_left),
			.chain_in (chain[gi]),
			.chain_out(chain[gi+1]),
			.fire     (fire_vec[gi])
		);
	end

	// walk decisions
	logic fire_cur;
	logic walk_stall;
	logic walk_step;

	assign fire_cur   = fire_vec[cnt_q];
	assign walk_stall = fire_cur && pend_v_q && !out_free;
	assign walk_step  = (state_q == wts_pkg::ST_WALK) && !walk_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wts_pkg::ST_IDLE: begin
				if (adv_acc) state_nxt = wts_pkg::ST_SCAN;
			end
			wts_pkg::ST_SCAN: begin
				if (cnt_q == LAST_IDX) state_nxt = wts_pkg::ST_APPLY;
			end
			wts_pkg::ST_APPLY: begin
				state_nxt = summary.any_wait ? wts_pkg::ST_WALK : wts_pkg::ST_IDLE_OUT;
			end
			wts_pkg::ST_IDLE_OUT: begin
				if (out_free) state_nxt = wts_pkg::ST_IDLE;
			end
			wts_pkg::ST_WALK: begin
				if (walk_step && (cnt_q == LAST_IDX)) state_nxt = wts_pkg::ST_FLUSH;
			end
			wts_pkg::ST_FLUSH: begin
				if (out_free) state_nxt = wts_pkg::ST_IDLE;
			end
			default: state_nxt = wts_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	logic                       emit;
	logic                       emit_idle;
	logic                       emit_last;
	logic                       pend_load;

	always_comb begin
		s_axis_tready = 1'b0;
		sub_en        = 1'b0;
		clr_en        = 1'b0;
		emit          = 1'b0;
		emit_idle     = 1'b0;
		emit_last     = 1'b0;
		pend_load     = 1'b0;
		case (state_q)
			wts_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			wts_pkg::ST_APPLY: begin
				sub_en = summary.any_wait && !summary.any_zero;
			end
			wts_pkg::ST_IDLE_OUT: begin
				emit      = out_free;
				emit_idle = 1'b1;
				emit_last = 1'b1;
			end
			wts_pkg::ST_WALK: begin
				if (walk_step && fire_cur) begin
					clr_en    = 1'b1;
					pend_load = 1'b1;
					emit      = pend_v_q;
				end
			end
			wts_pkg::ST_FLUSH: begin
				emit      = out_free;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wts_pkg::ST_IDLE;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			clock_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == wts_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == wts_pkg::ST_SCAN) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
			end else if (walk_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == wts_pkg::ST_APPLY) begin
				pend_v_q <= 1'b0;
			end else if (pend_load) begin
				pend_v_q <= 1'b1;
			end
			if (sub_en) begin
				clock_q <= clock_q + wts_pkg::TIME_W'(summary.min_left);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) pend_q <= cnt_q;
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_slot_q <= emit_idle ? '0 : wts_pkg::SLOT_W'(pend_q);
			out_time_q <= clock_q;
			out_idle_q <= emit_idle;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'b0, out_time_q, out_slot_q};
	assign m_axis_tuser  = out_idle_q;
	assign m_axis_tlast  = out_last_q;

	`include "assert_macros.svh"

	// a flush always has a pending report, since some slot fires whenever one waits
	`WTS_ASSERT_IMP(a_flush_pending, clk, arst_n, state_q == wts_pkg::ST_FLUSH, pend_v_q)
	// a result is never loaded over one that has not been taken
	`WTS_ASSERT_IMP(a_no_overwrite, clk, arst_n, emit, out_free)
	// the clock moves only on the step after the scan
	`WTS_ASSERT_NXT(a_clock_hold, clk, arst_n, state_q != wts_pkg::ST_APPLY, $stable(clock_q))

endmodule

`default_nettype wire
